// File: rtl/u8sd_pkg.sv
// Package for the UTF-8 stream decoder: beat types, status codes and
// decode constants. No dependencies.
package u8sd_pkg;

  localparam int unsigned CpW  = 21;
  localparam int unsigned StW  = 3;
  localparam int unsigned CntW = 3;

  typedef logic [StW-1:0] status_t;

  localparam status_t ST_OK         = 3'd0;
  localparam status_t ST_END        = 3'd1;
  localparam status_t ST_INCOMPLETE = 3'd2;
  localparam status_t ST_OVERLONG   = 3'd3;
  localparam status_t ST_BAD_LEN    = 3'd4;

  localparam logic [CpW-1:0] FLOOR_2B = 21'h000080;
  localparam logic [CpW-1:0] FLOOR_3B = 21'h000800;
  localparam logic [CpW-1:0] FLOOR_4B = 21'h010000;

  localparam logic [7:0] MASK_2B = 8'h1f;
  localparam logic [7:0] MASK_3B = 8'h0f;
  localparam logic [7:0] MASK_4B = 8'h07;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_in_buffer;
  } in_beat_t;

  typedef struct packed {
    logic [CpW-1:0]  code_point;
    status_t         status;
    logic [CntW-1:0] byte_count;
  } out_beat_t;

endpackage

// File: rtl/u8sd_core.sv
// Sequence tracker and decode logic for the UTF-8 stream decoder.
// Depends on u8sd_pkg.
module u8sd_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  u8sd_pkg::in_beat_t  beat,
  output logic                res_valid,
  output u8sd_pkg::out_beat_t res
);
  import u8sd_pkg::*;

  logic [1:0]     need_r, need_nxt;
  logic [2:0]     len_r, len_nxt;
  logic [CpW-1:0] gath_r, gath_nxt;

  logic [CpW-1:0] shifted;
  logic [1:0]     need_dec;
  logic [CpW-1:0] floor_val;

  assign shifted  = {gath_r[CpW-7:0], beat.data_byte[5:0]};
  assign need_dec = need_r - 2'd1;

  always_comb begin
    unique case (len_r)
      3'd2:    floor_val = FLOOR_2B;
      3'd3:    floor_val = FLOOR_3B;
      default: floor_val = FLOOR_4B;
    endcase
  end

  always_comb begin
    need_nxt  = need_r;
    len_nxt   = len_r;
    gath_nxt  = gath_r;
    res_valid = 1'b0;
    res       = '0;
    if (need_r == 2'd0) begin
      if (beat.data_byte == 8'h00) begin
        res_valid = 1'b1;
        res       = '{code_point: '0, status: ST_END, byte_count: 3'd1};
      end else if (beat.data_byte < 8'hc0 || beat.data_byte >= 8'hfe) begin
        res_valid = 1'b1;
        res       = '{code_point: {13'd0, beat.data_byte}, status: ST_OK, byte_count: 3'd1};
      end else if (beat.data_byte >= 8'hf8) begin
        res_valid = 1'b1;
        res       = '{code_point: '0, status: ST_BAD_LEN, byte_count: 3'd1};
      end else if (beat.last_in_buffer) begin
        // Lead byte is the last of the buffer: drop it
        res_valid = 1'b1;
        res       = '{code_point: '0, status: ST_INCOMPLETE, byte_count: 3'd1};
      end else if (beat.data_byte >= 8'hf0) begin
        len_nxt  = 3'd4;
        need_nxt = 2'd3;
        gath_nxt = {13'd0, beat.data_byte & MASK_4B};
      end else if (beat.data_byte >= 8'he0) begin
        len_nxt  = 3'd3;
        need_nxt = 2'd2;
        gath_nxt = {13'd0, beat.data_byte & MASK_3B};
      end else begin
        len_nxt  = 3'd2;
        need_nxt = 2'd1;
        gath_nxt = {13'd0, beat.data_byte & MASK_2B};
      end
    end else if (need_dec == 2'd0) begin
      res_valid = 1'b1;
      need_nxt  = 2'd0;
      len_nxt   = 3'd0;
      gath_nxt  = '0;
      if (shifted < floor_val) begin
        res = '{code_point: '0, status: ST_OVERLONG, byte_count: len_r};
      end else begin
        res = '{code_point: shifted, status: ST_OK, byte_count: len_r};
      end
    end else if (beat.last_in_buffer) begin
      res_valid = 1'b1;
      res       = '{code_point: '0, status: ST_INCOMPLETE,
                    byte_count: len_r - {1'b0, need_dec}};
      need_nxt  = 2'd0;
      len_nxt   = 3'd0;
      gath_nxt  = '0;
    end else begin
      need_nxt = need_dec;
      gath_nxt = shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      need_r <= 2'd0;
      len_r  <= 3'd0;
      gath_r <= '0;
    end else if (step) begin
      need_r <= need_nxt;
      len_r  <= len_nxt;
      gath_r <= gath_nxt;
    end
  end

endmodule

// File: rtl/u8sd_out_reg.sv
// Result register of the UTF-8 stream decoder: holds one result beat
// until the receiver takes it. Depends on u8sd_pkg.
module u8sd_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic                load_valid,
  input  u8sd_pkg::out_beat_t load_data,
  output logic                free,
  output logic                out_valid,
  input  logic                out_stall,
  output u8sd_pkg::out_beat_t out_data
);
  import u8sd_pkg::*;

  logic      valid_r;
  out_beat_t data_r;

  assign free      = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= load_valid;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      data_r <= load_data;
    end
  end

endmodule

// File: rtl/utf8_stream_decoder.sv
// UTF-8 stream decoder, top level. Uses u8sd_pkg, u8sd_core, u8sd_out_reg.
// A result is on out_valid once its last byte has passed the input register
// and then the result register; out_stall can hold it in either of them.
// Throughput: one byte per cycle while out_stall is low; each decode step
// updates the pending-sequence registers, so bytes may arrive back to back.
// Reset (rst_n low, synchronous): drop any pending sequence and empty both
// registers.
module utf8_stream_decoder (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  u8sd_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output u8sd_pkg::out_beat_t out_data
);
  import u8sd_pkg::*;

  // Input register: one byte beat waiting to be decoded.
  logic     in_valid_r;
  in_beat_t in_data_r;

  // Decode fires when a byte is held and the result register can take
  // its outcome (even when that byte produces no result).
  logic      out_free;
  logic      step;
  logic      res_valid;
  out_beat_t res;

  assign step     = in_valid_r && out_free;
  // Hold the input side only while a held byte cannot advance.
  assign in_stall = in_valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_data_r <= in_data;
    end
  end

  // Sequence state and per-byte decode.
  u8sd_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .beat      (in_data_r),
    .res_valid (res_valid),
    .res       (res)
  );

  // Result register: load on every decode step, bubble when no result.
  u8sd_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step),
    .load_valid (res_valid),
    .load_data  (res),
    .free       (out_free),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  // Stall is only raised with a byte actually held.
  a_stall_has_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r)
    else $error("in_stall raised with empty input register");

  // Any error or end status carries a zero code point.
  a_err_zero_cp: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |-> (out_data.code_point == '0))
    else $error("non-ok result with nonzero code point");

  // Byte count stays within one to four.
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.byte_count >= 3'd1 && out_data.byte_count <= 3'd4))
    else $error("byte_count out of range");

  // End of text and bad length always come from a single byte.
  a_single_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == ST_END || out_data.status == ST_BAD_LEN))
      |-> (out_data.byte_count == 3'd1))
    else $error("single-byte status with wrong byte_count");

endmodule
